// File: rtl/pvs_pkg.sv
// Shared constants of the polygon vertex smoother.
`default_nettype none
package pvs_pkg;

  localparam int CoordBitsDefault    = 16;
  localparam int FractionBitsDefault = 4;
  localparam int AlphaMaxBits        = 10;
  localparam int AlphaBits           = 9;
  localparam logic [AlphaBits-1:0] AlphaFull = 9'd341;
  localparam logic [AlphaBits-1:0] AlphaLow  = 9'd141;
  localparam logic [AlphaBits-1:0] AlphaHigh = 9'd256;
  localparam logic [AlphaMaxBits-1:0] AlphaMaxReset = 10'd256;

endpackage : pvs_pkg
`default_nettype wire

// File: rtl/polygon_vertex_smoother.sv
// Top level of the polygon vertex smoother.
// Vertices of a closed polygon stream in one word per vertex; each vertex j gets
// a corner or Bezier segment from its ring neighbours. Vertex n (n >= 2) yields
// the segment of vertex n-1; the last vertex yields two more (itself and vertex 0).
// A polygon under three vertices yields one degenerate word. A segment whose alpha
// needs the divide passes through: take the job; differences, cross product and
// magnitude; setup and the eleven-step restoring alpha divider; decide, interpolate
// and register the word. A segment whose alpha follows from a zero denominator or
// a small cross product skips the divider, and a degenerate word goes from the
// differences straight to the output register. A cross product of 2^52 or more (wide
// coordinates only) is halved with the denominator until it drops below 2^52. A vertex
// thus costs one segment time, the last vertex of a polygon three; the front end hands
// triangles through a two-entry queue and a waiting output word holds the back end.
// Write alpha_max (Q2.8) only while idle.
`default_nettype none
module polygon_vertex_smoother #(
  parameter int COORD_BITS    = pvs_pkg::CoordBitsDefault,
  parameter int FRACTION_BITS = pvs_pkg::FractionBitsDefault
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // vertex_x, vertex_y
  input  wire logic [((2*COORD_BITS+7)/8)*8-1:0]  s_axis_tdata,
  input  wire logic                               s_axis_tlast,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // is_curve, ctrl_a_x, ctrl_a_y, ctrl_b_x, ctrl_b_y, end_x, end_y, alpha_out, degenerate
  output logic [((6*COORD_BITS+pvs_pkg::AlphaBits+2+7)/8)*8-1:0] m_axis_tdata,
  output logic                                    m_axis_tlast,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [pvs_pkg::AlphaMaxBits-1:0]   cfg_data
);
  import pvs_pkg::*;

  localparam int JW = 6*COORD_BITS + 2;
  localparam int OW = 6*COORD_BITS + AlphaBits + 3;
  localparam int TDW = ((6*COORD_BITS+AlphaBits+2+7)/8)*8;

  logic [AlphaMaxBits-1:0] alpha_max;
  logic          fj_valid, fj_ready, bj_valid, bj_ready;
  logic [JW-1:0] fj_data, bj_data;
  logic [OW-1:0] res;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) alpha_max <= AlphaMaxReset;
    else if (cfg_valid) alpha_max <= cfg_data;
  end

  pvs_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_x(s_axis_tdata[COORD_BITS-1:0]),
    .in_y(s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .in_last(s_axis_tlast),
    .job_valid(fj_valid), .job_ready(fj_ready), .job_data(fj_data));

  pvs_fifo #(.WIDTH(JW)) u_queue (
    .clk, .rst,
    .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj_data),
    .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj_data));

  pvs_back #(.COORD_BITS(COORD_BITS), .FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk, .rst, .alpha_max,
    .job_valid(bj_valid), .job_ready(bj_ready), .job_data(bj_data),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_word(res));

  // Drop the last flag into tlast; the rest packs into tdata.
  assign m_axis_tdata = TDW'(res[OW-2:0]);
  assign m_axis_tlast = res[OW-1];

endmodule : polygon_vertex_smoother
`default_nettype wire

// File: rtl/pvs_front.sv
// Front end: accept vertices, keep the ring window and queue triangle jobs.
`default_nettype none
module pvs_front #(
  parameter int COORD_BITS = pvs_pkg::CoordBitsDefault
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [COORD_BITS-1:0]   in_x,
  input  wire logic [COORD_BITS-1:0]   in_y,
  input  wire logic                    in_last,
  // job queue write side
  output logic                         job_valid,
  input  wire logic                    job_ready,
  output logic [6*COORD_BITS+2-1:0]    job_data
);
  import pvs_pkg::*;

  localparam int CW = COORD_BITS;

  logic [CW-1:0] f0x, f0y, f1x, f1y, w0x, w0y, w1x, w1y, cx, cy;
  logic [1:0]    count;          // saturates at 2
  logic          busy;           // emitting the triangles of one vertex
  logic [1:0]    step;           // which job of the current vertex
  logic          cur_last;

  logic          need_mid;
  logic          last_job;

  // Job packing: {last, degen, pk, pj, pi}, points as {y,x}.
  function automatic logic [6*CW+2-1:0] pack(
    input logic deg, input logic lst,
    input logic [CW-1:0] ix, input logic [CW-1:0] iy,
    input logic [CW-1:0] jx, input logic [CW-1:0] jy,
    input logic [CW-1:0] kx, input logic [CW-1:0] ky);
    pack = {lst, deg, ky, kx, jy, jx, iy, ix};
  endfunction

  assign in_ready = !busy;
  assign need_mid = (count == 2'd2);

  always_comb begin
    job_data = '0;
    last_job = 1'b0;
    job_valid = busy;
    case (step)
      2'd0: begin
        job_data = pack(1'b0, 1'b0, w0x, w0y, w1x, w1y, cx, cy);
        last_job = !cur_last;
      end
      2'd1: job_data = pack(1'b0, 1'b0, w1x, w1y, cx, cy, f0x, f0y);
      2'd2: begin
        job_data = pack(1'b0, 1'b1, cx, cy, f0x, f0y, f1x, f1y);
        last_job = 1'b1;
      end
      default: begin
        job_data = pack(1'b1, 1'b1, '0, '0, '0, '0, '0, '0);
        last_job = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= 2'd0;
      step <= 2'd0;
      cur_last <= 1'b0;
      f0x <= '0; f0y <= '0; f1x <= '0; f1y <= '0;
      w0x <= '0; w0y <= '0; w1x <= '0; w1y <= '0;
    end else if (!busy) begin
      if (in_valid) begin
        cx <= in_x;
        cy <= in_y;
        cur_last <= in_last;
        if (in_last) begin
          busy <= 1'b1;
          step <= need_mid ? 2'd0 : 2'd3;
        end else begin
          if (count == 2'd0) begin f0x <= in_x; f0y <= in_y; end
          if (count == 2'd1) begin f1x <= in_x; f1y <= in_y; end
          if (count != 2'd2) count <= count + 2'd1;
          // Keep window current when a non-emitting vertex arrives.
          if (!need_mid) begin
            w0x <= w1x; w0y <= w1y; w1x <= in_x; w1y <= in_y;
          end
          busy <= need_mid;
          step <= 2'd0;
        end
      end
    end else if (job_ready) begin
      if (last_job) begin
        busy <= 1'b0;
        if (cur_last) count <= 2'd0;
        else begin
          w0x <= w1x; w0y <= w1y; w1x <= cx; w1y <= cy;
        end
      end else begin
        step <= step + 2'd1;
      end
    end
  end

endmodule : pvs_front
`default_nettype wire

// File: rtl/pvs_fifo.sv
// Short job queue between the front end and the back end.
`default_nettype none
module pvs_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_valid,
  output logic                  wr_ready,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  rd_valid,
  input  wire logic             rd_ready,
  output logic [WIDTH-1:0]      rd_data
);
  logic [WIDTH-1:0] mem [2];
  logic             wp, rp;
  logic [1:0]       fill;

  assign wr_ready = (fill != 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; fill <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wp <= !wp;
      if (rd_valid && rd_ready) rp <= !rp;
      fill <= fill + {1'b0, wr_valid && wr_ready} - {1'b0, rd_valid && rd_ready};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) fill != 2'd3)
    else $error("queue fill out of range");
  a_empty_no_read: assert property (@(posedge clk) disable iff (rst)
    (fill == 2'd0) |-> !rd_valid) else $error("read valid on empty queue");
  a_full_no_write: assert property (@(posedge clk) disable iff (rst)
    (fill == 2'd2) |-> !wr_ready) else $error("write ready on full queue");

endmodule : pvs_fifo
`default_nettype wire

// File: rtl/pvs_back.sv
// Back end: cross product, serial alpha divider, interpolation and output register.
`default_nettype none
module pvs_back #(
  parameter int COORD_BITS    = pvs_pkg::CoordBitsDefault,
  parameter int FRACTION_BITS = pvs_pkg::FractionBitsDefault
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic [pvs_pkg::AlphaMaxBits-1:0]    alpha_max,
  input  wire logic                                job_valid,
  output logic                                     job_ready,
  input  wire logic [6*COORD_BITS+2-1:0]           job_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [6*COORD_BITS+pvs_pkg::AlphaBits+3-1:0] out_word
);
  import pvs_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int DW = CW + 1;                 // difference width
  localparam int PW = 2 * DW;                 // product width
  localparam int XW = PW + 1;                 // cross width
  localparam int TW = DW + 1 + FRACTION_BITS; // denominator width
  localparam int NB = 52;                     // cross kept below 2^NB for the divide
  localparam int DB = (XW < NB) ? XW : NB;    // bits of the cross at the divider
  localparam int NW = DB + 14;
  localparam int QB = 11;                     // quotient bits (quotient <= 341)
  localparam int LW = 10;                     // lambda factor 256+a

  localparam logic [3:0] S_IDLE = 4'd0, S_MUL = 4'd1, S_CROSS = 4'd2,
                         S_NORM = 4'd3, S_DIV = 4'd4, S_DEC = 4'd5,
                         S_LA = 4'd6, S_LB = 4'd7, S_LC = 4'd8, S_LD = 4'd9,
                         S_OUT = 4'd10;

  logic [3:0]    state;
  logic [CW-1:0] ix, iy, jx, jy, kx, ky;
  logic          jdeg, jlast;
  logic signed [DW-1:0] x1, y1, x2, y2;
  logic signed [PW-1:0] pa, pb;
  logic [XW-1:0] dmag;
  logic [TW-1:0] tval;
  logic [NW-1:0] rem, divisor;
  logic [QB-1:0] quo;
  logic [3:0]    qcnt;
  logic [AlphaBits-1:0] alpha;
  logic          is_curve;
  logic [LW-1:0] lam;
  logic signed [CW-1:0] ax, ay, bx, by, ex, ey;

  function automatic logic signed [CW-1:0] sat(input logic signed [CW+LW+2:0] v);
    logic signed [CW+LW+2:0] hi, lo;
    hi = (CW+LW+3)'({1'b0, {(CW-1){1'b1}}});
    lo = -hi - (CW+LW+3)'(1);
    if (v > hi) sat = {1'b0, {(CW-1){1'b1}}};
    else if (v < lo) sat = {1'b1, {(CW-1){1'b0}}};
    else sat = v[CW-1:0];
  endfunction

  // from + floor(((256+a)*(to-from)+256)/512)
  function automatic logic signed [CW-1:0] lerp(input logic signed [CW-1:0] f,
      input logic signed [CW-1:0] t, input logic [LW-1:0] l);
    logic signed [CW+LW+2:0] p;
    p = $signed({1'b0, l}) * ((CW+LW+3)'(t) - (CW+LW+3)'(f)) + (CW+LW+3)'(256);
    lerp = sat((CW+LW+3)'(f) + (p >>> 9));
  endfunction

  logic signed [CW+LW+2:0] mid_x, mid_y;
  assign mid_x = ((CW+LW+3)'($signed(jx)) + (CW+LW+3)'($signed(kx))
                  + (CW+LW+3)'(1)) >>> 1;
  assign mid_y = ((CW+LW+3)'($signed(jy)) + (CW+LW+3)'($signed(ky))
                  + (CW+LW+3)'(1)) >>> 1;

  logic [DW-1:0] adx, ady;
  assign adx = x2[DW-1] ? DW'(-x2) : DW'(x2);
  assign ady = y2[DW-1] ? DW'(-y2) : DW'(y2);

  logic signed [XW-1:0] crs;
  assign crs = XW'(pa) - XW'(pb);

  logic [NW:0] trial;
  assign trial = {rem, 1'b0} - {1'b0, divisor};

  assign job_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_LD && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (job_valid) begin
          {jlast, jdeg, ky, kx, jy, jx, iy, ix} <= job_data;
          state <= S_MUL;
        end
        S_MUL: begin
          x1 <= DW'($signed(jx)) - DW'($signed(ix));
          y1 <= DW'($signed(jy)) - DW'($signed(iy));
          x2 <= DW'($signed(kx)) - DW'($signed(ix));
          y2 <= DW'($signed(ky)) - DW'($signed(iy));
          state <= jdeg ? S_OUT : S_CROSS;
        end
        S_CROSS: begin
          pa <= x1 * y2;
          pb <= x2 * y1;
          tval <= TW'({1'b0, adx} + {1'b0, ady}) << FRACTION_BITS;
          state <= S_NORM;
        end
        S_NORM: begin
          dmag <= crs[XW-1] ? XW'(-crs) : XW'(crs);
          state <= S_DIV;
          qcnt <= 4'd0;
        end
        S_DIV: begin
          if (qcnt == 4'd0) begin
            if (tval == '0) begin
              alpha <= AlphaFull; state <= S_DEC;
            end else if (dmag <= XW'(tval)) begin
              alpha <= '0; state <= S_DEC;
            end else begin
              quo <= '0;
              qcnt <= 4'd1;
            end
          end else if (qcnt == 4'd1) begin
            // halve D and T together until D drops below 2^NB
            if ((dmag >> NB) != '0) begin
              dmag <= dmag >> 1;
              tval <= tval >> 1;
            end else begin
              // alpha = floor((2048(D-T)+3D)/(6D))
              rem <= (NW'(dmag - XW'(tval)) << 11) + NW'(dmag) * NW'(3);
              divisor <= NW'(dmag) * NW'(6);
              qcnt <= 4'd2;
            end
          end else begin
            // one quotient bit per cycle, restoring
            if (qcnt == 4'd2) begin
              quo <= '0;
              divisor <= divisor << QB;
              qcnt <= 4'd3;
              lam <= LW'(QB);
            end else begin
              if (!trial[NW]) begin
                rem <= trial[NW-1:0];
                quo <= {quo[QB-2:0], 1'b1};
              end else begin
                rem <= {rem[NW-2:0], 1'b0};
                quo <= {quo[QB-2:0], 1'b0};
              end
              lam <= lam - LW'(1);
              if (lam == LW'(1)) begin
                state <= S_DEC;
                qcnt <= 4'd15;
              end
            end
          end
        end
        S_DEC: begin
          logic [AlphaBits-1:0] a;
          a = (qcnt == 4'd15) ? AlphaBits'(quo) : alpha;
          if ({1'b0, a} >= alpha_max) begin
            is_curve <= 1'b0;
            alpha <= a;
          end else begin
            is_curve <= 1'b1;
            alpha <= (a < AlphaLow) ? AlphaLow : (a > AlphaHigh) ? AlphaHigh : a;
          end
          ex <= sat(mid_x);
          ey <= sat(mid_y);
          state <= S_LA;
        end
        S_LA: begin lam <= LW'(AlphaHigh) + LW'(alpha); state <= S_LB; end
        S_LB: begin ax <= lerp(ix, jx, lam); ay <= lerp(iy, jy, lam); state <= S_LC; end
        S_LC: begin bx <= lerp(kx, jx, lam); by <= lerp(ky, jy, lam); state <= S_LD; end
        S_LD: if (!out_valid || out_ready) begin
          if (jdeg) begin
            out_word <= {1'b1, 1'b1, {AlphaBits{1'b0}}, {(6*CW){1'b0}}, 1'b0};
          end else if (is_curve) begin
            out_word <= {jlast, 1'b0, alpha, ey, ex, by, bx, ay, ax, 1'b1};
          end else begin
            out_word <= {jlast, 1'b0, alpha, ey, ex, jy, jx, {(2*CW){1'b0}}, 1'b0};
          end
          state <= S_IDLE;
        end
        S_OUT: state <= S_LD;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !job_ready) else $error("job taken while busy");
  a_alpha: assert property (@(posedge clk) disable iff (rst)
    (state == S_LA) |-> (alpha <= AlphaFull)) else $error("alpha out of range");
  a_div_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && qcnt >= 4'd3) |-> (lam != '0)) else $error("divider overrun");

endmodule : pvs_back
`default_nettype wire
